// ===== rtl/core/dochf_pkg.sv =====
// Package for the drop-oldest chunk FIFO: payload structs, codes and sizes.
// Used by every file of the block; depends on nothing.
package dochf_pkg;

  localparam int MaxFrames   = 4096;
  localparam int SampleDepth = 2 * MaxFrames;
  localparam int CntW        = $clog2(MaxFrames + 1);
  localparam int ChW         = $clog2(MaxFrames);
  localparam int SmW         = $clog2(SampleDepth);
  localparam logic [47:0] DropMax = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLOSE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_PUSHED      = 3'd0,
    ST_POPPED      = 3'd1,
    ST_REFUSED     = 3'd2,
    ST_WAIT        = 3'd3,
    ST_CLOSED_EMPT = 3'd4,
    ST_CLOSED      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT_RD,
    S_EVICT,
    S_POP_RD,
    S_POP_LEN,
    S_POP_SMP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] sample;
    logic [12:0] chunk_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] sample_out;
    logic        chunk_end;
    logic [13:0] chunk_dropped;
    logic [12:0] queued_count;
    logic [47:0] dropped_total;
  } out_item_t;

endpackage

// ===== rtl/core/drop_oldest_chunk_fifo_unit.sv =====
// Drop-oldest chunk FIFO: the top level, with its state machine and both rings.
// Depends on dochf_pkg.
//
// Usage. Items enter on in_valid/in_ready as in_data (push, pop or close) and
// each gives exactly one result on out_valid/out_ready as out_data. The
// capacity register is written over cfg_valid/cfg_ready; the user must write
// it only while the block idles, and the block itself does not enforce this.
// Path from one acceptance to the next: a push that continues a chunk, and a
// close, go straight to the output state. The first sample of a chunk reads
// the oldest length, then walks the length ring, one memory read per evicted
// chunk, or goes straight to output when refused. A pop that detaches a new
// chunk first reads its length, since the length and sample rings have
// registered reads. The result register loads as the block returns to idle.
// One item is in flight at a time; the next is taken once the result has
// moved into the output register, even while the receiver still stalls it.
// Reset clears pointers, counts and the closed flag; it does not clear the
// rings, so no clearing pass is needed. A stalled receiver holds out_data; the
// item behind it is still processed, but its result waits in the last state
// until the output register frees, and no further item is taken meanwhile.
module drop_oldest_chunk_fifo_unit
  import dochf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [12:0] cfg_data
);

  logic [31:0] smp_mem [SampleDepth];
  logic [12:0] len_mem [MaxFrames];

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  logic [SmW-1:0] s_head_r, s_head_nxt, s_tail_r, s_tail_nxt, lst_r, lst_nxt;
  logic [ChW-1:0] c_head_r, c_head_nxt, c_tail_r, c_tail_nxt;
  logic [CntW-1:0] c_cnt_r, c_cnt_nxt, qf_r, qf_nxt;
  logic [47:0] tot_r, tot_nxt;
  logic closed_r, closed_nxt, refused_r, refused_nxt;
  logic [12:0] prog_r, prog_nxt, trim_r, trim_nxt, rleft_r, rleft_nxt;
  logic [13:0] dacc_r, dacc_nxt;
  logic [12:0] kept_r, kept_nxt, cap_r;
  logic [13:0] drop_r, drop_nxt;
  out_item_t res_r, res_nxt;
  logic ov_r, ov_nxt;

  logic [12:0] len_q;
  logic [31:0] smp_q;
  logic len_we, smp_we;
  logic [ChW-1:0] len_wa, len_ra;
  logic [12:0] len_wd;
  logic [SmW-1:0] smp_ra;

  logic [12:0] cap_eff, n_len;

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    len_q <= len_mem[len_ra];
    if (smp_we) smp_mem[s_tail_r] <= item_r.sample;
    smp_q <= smp_mem[smp_ra];
  end

  assign cap_eff = (cap_r == 13'd0) ? 13'd1 :
                   (cap_r > 13'(MaxFrames)) ? 13'(MaxFrames) : cap_r;
  assign n_len = (item_r.chunk_length == 13'd0) ? 13'd1 : item_r.chunk_length;
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0;
      s_head_r <= '0; s_tail_r <= '0; lst_r <= '0;
      c_head_r <= '0; c_tail_r <= '0; c_cnt_r <= '0; qf_r <= '0;
      tot_r <= '0; closed_r <= 1'b0; refused_r <= 1'b0;
      prog_r <= '0; trim_r <= '0; rleft_r <= '0; dacc_r <= '0;
      cap_r <= 13'd4096;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
      s_head_r <= s_head_nxt; s_tail_r <= s_tail_nxt; lst_r <= lst_nxt;
      c_head_r <= c_head_nxt; c_tail_r <= c_tail_nxt; c_cnt_r <= c_cnt_nxt;
      qf_r <= qf_nxt; tot_r <= tot_nxt; closed_r <= closed_nxt;
      refused_r <= refused_nxt; prog_r <= prog_nxt; trim_r <= trim_nxt;
      rleft_r <= rleft_nxt; dacc_r <= dacc_nxt;
      if (cfg_valid) cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    kept_r <= kept_nxt;
    drop_r <= drop_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    logic [48:0] tsum;
    logic [12:0] pleft;
    state_nxt = state_r; ov_nxt = ov_r;
    item_nxt = item_r; kept_nxt = kept_r; drop_nxt = drop_r; res_nxt = res_r;
    s_head_nxt = s_head_r; s_tail_nxt = s_tail_r; lst_nxt = lst_r;
    c_head_nxt = c_head_r; c_tail_nxt = c_tail_r; c_cnt_nxt = c_cnt_r;
    qf_nxt = qf_r; tot_nxt = tot_r; closed_nxt = closed_r;
    refused_nxt = refused_r; prog_nxt = prog_r; trim_nxt = trim_r;
    rleft_nxt = rleft_r; dacc_nxt = dacc_r;
    len_we = 1'b0; len_wa = c_tail_r; len_wd = kept_r; len_ra = c_head_r;
    smp_we = 1'b0; smp_ra = s_head_r;
    tsum = '0; pleft = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          item_nxt = in_data;
          case (req_t'(in_data.req_type))
            REQ_PUSH: state_nxt = (prog_r == 13'd0) ? S_EVICT_RD : S_OUT;
            REQ_POP:  state_nxt = (rleft_r == 13'd0 && c_cnt_r != '0) ?
                                  S_POP_RD : S_POP_SMP;
            default:  state_nxt = S_OUT;
          endcase
          if (req_t'(in_data.req_type) == REQ_PUSH && prog_r == 13'd0) begin
            kept_nxt = 13'd0;
            drop_nxt = 14'd0;
          end
        end
      end
      S_EVICT_RD: begin
        // Chunk start: fix acceptance, trim and the first guess of drops.
        prog_nxt = n_len;
        if (closed_r) begin
          refused_nxt = 1'b1; trim_nxt = '0; dacc_nxt = {1'b0, n_len};
          state_nxt = S_OUT;
        end else begin
          refused_nxt = 1'b0;
          kept_nxt = (n_len > cap_eff) ? cap_eff : n_len;
          drop_nxt = {1'b0, n_len - ((n_len > cap_eff) ? cap_eff : n_len)};
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        // len_q holds the length of the oldest chunk, read last cycle.
        if (c_cnt_r != '0 && ({1'b0, qf_r} + {1'b0, kept_r}) > {1'b0, cap_eff}) begin
          drop_nxt = drop_r + {1'b0, len_q};
          qf_nxt = (len_q > qf_r) ? '0 : qf_r - len_q;
          lst_nxt = lst_r + SmW'(len_q);
          c_head_nxt = c_head_r + 1'b1;
          c_cnt_nxt = c_cnt_r - 1'b1;
          // Read the new head's length; the check resumes after the read latency.
          len_ra = c_head_r + 1'b1;
          state_nxt = S_POP_LEN;
        end else begin
          qf_nxt = qf_r + kept_r;
          len_we = 1'b1;
          trim_nxt = prog_r - kept_r;
          dacc_nxt = drop_r;
          tsum = {1'b0, tot_r} + 49'(drop_r);
          tot_nxt = (tsum > {1'b0, DropMax}) ? DropMax : tsum[47:0];
          state_nxt = S_OUT;
        end
      end
      S_POP_LEN: begin
        // Wait state used by eviction and by a pop that detaches a chunk: head length is being read now.
        len_ra = c_head_r;
        state_nxt = (item_r.req_type == REQ_PUSH) ? S_EVICT : S_POP_SMP;
      end
      S_POP_RD: begin
        len_ra = c_head_r;
        state_nxt = S_POP_LEN;
      end
      S_POP_SMP: begin
        if (item_r.req_type == REQ_POP && rleft_r == 13'd0 && c_cnt_r != '0) begin
          qf_nxt = (len_q > qf_r) ? '0 : qf_r - len_q;
          s_head_nxt = lst_r;
          lst_nxt = lst_r + SmW'(len_q);
          rleft_nxt = len_q;
          c_head_nxt = c_head_r + 1'b1;
          c_cnt_nxt = c_cnt_r - 1'b1;
          smp_ra = lst_r;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // The item commits only once the output register is free.
        if (!ov_r || out_ready) begin
          res_nxt = '0;
          res_nxt.status = ST_WAIT;
          case (req_t'(item_r.req_type))
            REQ_PUSH: begin
              if (refused_r) begin
                res_nxt.status = ST_REFUSED;
              end else begin
                res_nxt.status = ST_PUSHED;
                if (trim_r != 13'd0) begin
                  trim_nxt = trim_r - 1'b1;
                end else begin
                  smp_we = 1'b1;
                  s_tail_nxt = s_tail_r + 1'b1;
                end
              end
              pleft = prog_r - 1'b1;
              prog_nxt = pleft;
              if (pleft == 13'd0) begin
                res_nxt.chunk_end = 1'b1;
                res_nxt.chunk_dropped = dacc_r;
                if (!refused_r) begin
                  c_tail_nxt = c_tail_r + 1'b1;
                  c_cnt_nxt = c_cnt_r + 1'b1;
                end
              end
            end
            REQ_POP: begin
              if (rleft_r != 13'd0) begin
                res_nxt.status = ST_POPPED;
                res_nxt.sample_out = smp_q;
                s_head_nxt = s_head_r + 1'b1;
                rleft_nxt = rleft_r - 1'b1;
                res_nxt.chunk_end = (rleft_r == 13'd1);
              end else if (closed_r && (prog_r == 13'd0 || refused_r)) begin
                res_nxt.status = ST_CLOSED_EMPT;
              end
            end
            REQ_CLOSE: begin
              closed_nxt = 1'b1;
              res_nxt.status = ST_CLOSED;
            end
            default: res_nxt.status = ST_WAIT;
          endcase
          res_nxt.queued_count = qf_r;
          res_nxt.dropped_total = tot_r;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/dochf_checker.sv =====
// Port-level checker for the drop-oldest chunk FIFO, bound to the top level.
// Depends on dochf_pkg.
module dochf_checker
  import dochf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_CLOSED)
    else $error("status code out of range");

  a_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_POPPED |-> out_data.sample_out == 32'd0)
    else $error("sample without a pop");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule

bind drop_oldest_chunk_fifo_unit dochf_checker u_dochf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== dv/drop_oldest_chunk_fifo_unit_checker.sv =====
// Checker for the drop-oldest chunk FIFO: watches all three channels, predicts
// every result and compares it as a whole. Depends on dochf_pkg.
`timescale 1ns / 100ps

module drop_oldest_chunk_fifo_unit_checker
  import dochf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [12:0] cfg_data,
  output int          mismatches,
  output int          awaited,
  output int          frames_left
);

  out_item_t   expected_q[$];
  logic [31:0] sample_mem[SampleDepth];
  logic [12:0] length_mem[MaxFrames];
  logic [12:0] cap_reg = 13'd4096;
  int          smp_head = 0, smp_tail = 0, ch_head = 0, ch_tail = 0, ch_count = 0;
  int          queued = 0, progress = 0, trim_left = 0, drop_acc = 0;
  int          read_left = 0, list_start = 0;
  logic [47:0] drop_total = '0;
  bit          closed = 0, refused = 0;

  assign frames_left = queued + read_left;

  function automatic int effective_cap();
    if (cap_reg == 0) return 1;
    return (cap_reg > MaxFrames) ? MaxFrames : int'(cap_reg);
  endfunction

  // Acceptance, front trim and eviction are all settled at a chunk's first sample.
  function automatic void open_chunk(logic [12:0] len);
    int     n, cap, kept, l;
    longint dropped;
    n = (len == 0) ? 1 : int'(len);
    progress = n;
    if (closed) begin
      refused   = 1;
      trim_left = 0;
      drop_acc  = n;
      return;
    end
    refused = 0;
    cap     = effective_cap();
    kept    = (n > cap) ? cap : n;
    dropped = n - kept;
    while (ch_count > 0 && queued + kept > cap) begin
      l          = int'(length_mem[ch_head]);
      dropped   += l;
      queued     = (l > queued) ? 0 : queued - l;
      list_start = (list_start + l) % SampleDepth;
      ch_head    = (ch_head + 1) % MaxFrames;
      ch_count--;
    end
    queued             += kept;
    length_mem[ch_tail] = kept[12:0];
    trim_left           = n - kept;
    drop_acc            = int'(dropped);
    if (dropped > longint'(DropMax - drop_total)) drop_total = DropMax;
    else drop_total = drop_total + dropped[47:0];
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int        l;
    r = '0;
    r.status = ST_WAIT;
    if (it.req_type == REQ_PUSH) begin
      if (progress == 0) open_chunk(it.chunk_length);
      if (refused) begin
        r.status = ST_REFUSED;
      end else begin
        r.status = ST_PUSHED;
        if (trim_left > 0) begin
          trim_left--;
        end else begin
          sample_mem[smp_tail] = it.sample;
          smp_tail = (smp_tail + 1) % SampleDepth;
        end
      end
      progress--;
      if (progress == 0) begin
        r.chunk_end     = 1'b1;
        r.chunk_dropped = drop_acc[13:0];
        if (!refused) begin
          ch_tail = (ch_tail + 1) % MaxFrames;
          ch_count++;
        end
      end
    end else if (it.req_type == REQ_POP) begin
      if (read_left == 0 && ch_count > 0) begin
        l          = int'(length_mem[ch_head]);
        queued     = (l > queued) ? 0 : queued - l;
        smp_head   = list_start;
        list_start = (list_start + l) % SampleDepth;
        read_left  = l;
        ch_head    = (ch_head + 1) % MaxFrames;
        ch_count--;
      end
      if (read_left > 0) begin
        r.status     = ST_POPPED;
        r.sample_out = sample_mem[smp_head];
        smp_head     = (smp_head + 1) % SampleDepth;
        read_left--;
        r.chunk_end  = (read_left == 0);
      end else if (closed && (progress == 0 || refused)) begin
        r.status = ST_CLOSED_EMPT;
      end
    end else if (it.req_type == REQ_CLOSE) begin
      closed   = 1;
      r.status = ST_CLOSED;
    end
    r.queued_count  = queued[12:0];
    r.dropped_total = drop_total;
    return r;
  endfunction

  initial begin
    mismatches = 0;
    awaited    = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      // Results are compared before the new item is predicted, so a result can
      // never be matched against an item accepted at the same edge.
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected st=%0d smp=%h end=%b drop=%0d q=%0d tot=%0d",
                       want.status, want.sample_out, want.chunk_end,
                       want.chunk_dropped, want.queued_count, want.dropped_total);
              $display("  actual   st=%0d smp=%h end=%b drop=%0d q=%0d tot=%0d",
                       out_data.status, out_data.sample_out, out_data.chunk_end,
                       out_data.chunk_dropped, out_data.queued_count,
                       out_data.dropped_total);
            end
          end
        end
      end
      if (in_valid && in_ready)
        expected_q.insert(expected_q.size(), predict_result(in_data));
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      awaited = expected_q.size();
    end
  end

endmodule

// ===== dv/drop_oldest_chunk_fifo_unit_test.sv =====
// Top of the drop-oldest chunk FIFO testbench: clock, reset, stimulus and verdict.
// Depends on dochf_pkg, the block itself and drop_oldest_chunk_fifo_unit_checker.
`timescale 1ns / 100ps

module drop_oldest_chunk_fifo_unit_test;
  import dochf_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_item_t   out_data;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [12:0] cfg_data = '0;
  int          mismatches, awaited, frames_left;
  int          send_idle = 0, recv_idle = 0;
  int          chunk_rem = 0;
  int          cycles = 0;
  int          caps[6];

  drop_oldest_chunk_fifo_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  drop_oldest_chunk_fifo_unit_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .awaited(awaited), .frames_left(frames_left)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("drop_oldest_chunk_fifo_unit verification failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(req_t req, logic [31:0] smp, logic [12:0] len);
    if ($urandom_range(99) < send_idle) begin
      in_valid = 0;
      do @(negedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid = 1;
    in_data  = '{req_type: req, sample: smp, chunk_length: len};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 0;
    while (awaited != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_capacity(logic [12:0] value);
    drain();
    cfg_valid = 1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // One push sample; a fresh chunk length is chosen when no chunk is open.
  task automatic push_sample(int len);
    logic [12:0] field;
    field = 13'($urandom);
    if (chunk_rem == 0) begin
      field     = len[12:0];
      chunk_rem = (len == 0) ? 1 : len;
    end
    send_item(REQ_PUSH, $urandom, field);
    chunk_rem--;
  endtask

  task automatic random_item();
    int pick, len;
    pick = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 8);
    if (pick < 55) push_sample(len);
    else if (pick < 95) send_item(REQ_POP, $urandom, 13'($urandom));
    else send_item(REQ_NONE, $urandom, 13'($urandom));
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    send_item(REQ_POP, 32'h0, 13'h1FFF);
    send_item(REQ_NONE, 32'hFFFF_FFFF, 13'h0);
    push_sample(0);
    send_item(REQ_PUSH, 32'hFFFF_FFFF, 13'd3);
    send_item(REQ_PUSH, 32'h8000_0001, 13'h1FFF);
    send_item(REQ_PUSH, 32'h7FFF_FFFE, 13'h0);
    repeat (5) send_item(REQ_POP, 32'h0, 13'h0);
    // A pop while only an unfinished chunk exists must wait.
    send_item(REQ_PUSH, 32'h1234_5678, 13'd2);
    send_item(REQ_POP, 32'h0, 13'h0);
    send_item(REQ_PUSH, 32'hCAFE_F00D, 13'd2);
    write_capacity(13'd2);
    chunk_rem = 0;
    repeat (5) push_sample(5);
    push_sample(1);
    repeat (3) send_item(REQ_POP, 32'h0, 13'h0);

    caps = '{4096, 1, 0, 8191, 0, 3};
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 6 : (mode == 1) ? 50 : 0;
      recv_idle = (mode == 0) ? 50 : (mode == 1) ? 6 : 0;
      for (int c = 0; c < 6; c++) begin
        write_capacity((c == 4) ? 13'($urandom_range(2, 20)) : 13'(caps[c]));
        for (int k = 0; k < 55; k++) begin
          if (c == 2 && k == 25) drain();
          random_item();
        end
      end
    end

    // Closing: an accepted chunk still completes, a later one is refused whole.
    chunk_rem = 0;
    push_sample(3);
    send_item(REQ_CLOSE, $urandom, 13'($urandom));
    repeat (frames_left + 1) send_item(REQ_POP, 32'h0, 13'h0);
    push_sample(3);
    push_sample(3);
    push_sample(2);
    send_item(REQ_POP, 32'h0, 13'h0);
    push_sample(2);
    repeat (frames_left + 2) send_item(REQ_POP, 32'h0, 13'h0);
    send_item(REQ_PUSH, $urandom, 13'd0);

    drain();
    if (mismatches == 0 && awaited == 0) begin
      $display("drop_oldest_chunk_fifo_unit verification clean");
    end else begin
      $display("drop_oldest_chunk_fifo_unit verification failed");
    end
    $finish;
  end

endmodule
